// ===== hdl/lru_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU tag store package
// Shared field widths, default geometry, command codes and the status
// bundle passed from the way logic to the top level.
// ----------------------------------------------------------------------------
package lru_ts_pkg;

   // Fixed widths of the item fields at the ports.
   localparam int CMD_BITS        = 2;
   localparam int FIELD_ADDR_BITS = 48;

   // Default cache geometry.
   localparam int DEF_SET_BITS    = 2;
   localparam int DEF_WAYS        = 4;
   localparam int DEF_OFFSET_BITS = 6;
   localparam int DEF_ADDR_BITS   = 48;

   // Command codes; the reply kind uses the same codes.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_READ       = 2'd0,
      CMD_INVALIDATE = 2'd1,
      CMD_FETCH      = 2'd2,
      CMD_UPDATE     = 2'd3
   } cmd_type;

   // Outcome of one lookup.
   typedef struct packed {
      logic missing;
      logic evicted;
   } lookup_status_type;

endpackage

// ===== hdl/lru_ts_row_mem.sv =====
// ----------------------------------------------------------------------------
// LRU tag store row memory
// One row per set, one write port and one registered read port. A read
// that meets a write to the same row in the same cycle returns the new row.
// ----------------------------------------------------------------------------
module lru_ts_row_mem #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4,
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lru_ts_way_logic.sv =====
// ----------------------------------------------------------------------------
// LRU tag store way logic
// Compares all ways of one set at once, picks the hit, free or victim way
// and produces the updated row together with the lookup status.
// ----------------------------------------------------------------------------
module lru_ts_way_logic #(
   parameter int WAYS      = 4,
   parameter int TAG_BITS  = 40,
   localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [lru_ts_pkg::CMD_BITS-1:0]     cmd,
   input  logic [TAG_BITS-1:0]                 tag,
   input  logic [WAYS-1:0]                     cur_valid,
   input  logic [WAYS-1:0]                     cur_dirty,
   input  logic [WAYS-1:0][RANK_BITS-1:0]      cur_rank,
   input  logic [WAYS-1:0][TAG_BITS-1:0]       cur_tag,
   output logic [WAYS-1:0]                     nxt_valid,
   output logic [WAYS-1:0]                     nxt_dirty,
   output logic [WAYS-1:0][RANK_BITS-1:0]      nxt_rank,
   output logic [WAYS-1:0][TAG_BITS-1:0]       nxt_tag,
   output lru_ts_pkg::lookup_status_type       status,
   output logic [TAG_BITS-1:0]                 victim_tag
);

   import lru_ts_pkg::*;

   localparam logic [RANK_BITS-1:0] OLDEST = RANK_BITS'(WAYS - 1);

   logic [WAYS-1:0]      hit_oh;
   logic [WAYS-1:0]      free_oh;
   logic [WAYS-1:0]      lru_oh;
   logic [WAYS-1:0]      tgt_oh;
   logic                 found_hit;
   logic                 found_free;
   logic                 found_lru;
   logic                 is_update;
   logic                 fill;
   logic                 touch;
   logic                 drop;
   logic [RANK_BITS-1:0] sel_rank;
   logic [RANK_BITS-1:0] old_rank;
   logic [TAG_BITS-1:0]  lru_tag;

   // Way selection: lowest matching valid way, lowest free way, oldest way.
   always_comb begin
      hit_oh     = '0;
      free_oh    = '0;
      lru_oh     = '0;
      found_hit  = 1'b0;
      found_free = 1'b0;
      found_lru  = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (cur_valid[i] && (cur_tag[i] == tag) && !found_hit) begin
            hit_oh[i] = 1'b1;
            found_hit = 1'b1;
         end
         if (!cur_valid[i] && !found_free) begin
            free_oh[i] = 1'b1;
            found_free = 1'b1;
         end
         if ((cur_rank[i] == OLDEST) && !found_lru) begin
            lru_oh[i] = 1'b1;
            found_lru = 1'b1;
         end
      end
      if (!found_lru) begin
         lru_oh[0] = 1'b1;
      end
   end

   always_comb begin
      is_update = (cmd == CMD_UPDATE);
      fill      = is_update && !found_hit;
      touch     = found_hit ? (cmd != CMD_INVALIDATE) : is_update;
      drop      = found_hit && (cmd == CMD_INVALIDATE);
      if (found_hit) begin
         tgt_oh = hit_oh;
      end else if (found_free) begin
         tgt_oh = free_oh;
      end else begin
         tgt_oh = lru_oh;
      end
      sel_rank = '0;
      lru_tag  = '0;
      for (int i = 0; i < WAYS; i++) begin
         sel_rank = sel_rank | (tgt_oh[i] ? cur_rank[i] : '0);
         lru_tag  = lru_tag | (lru_oh[i] ? cur_tag[i] : '0);
      end
      // A filled line enters as the oldest before being touched.
      old_rank = fill ? OLDEST : sel_rank;
   end

   always_comb begin
      nxt_valid = cur_valid;
      nxt_dirty = cur_dirty;
      nxt_rank  = cur_rank;
      nxt_tag   = cur_tag;
      for (int i = 0; i < WAYS; i++) begin
         if (tgt_oh[i]) begin
            if (drop) begin
               nxt_valid[i] = 1'b0;
               nxt_rank[i]  = '0;
            end else if (touch) begin
               nxt_rank[i] = '0;
               if (fill) begin
                  nxt_valid[i] = 1'b1;
                  nxt_dirty[i] = 1'b1;
                  nxt_tag[i]   = tag;
               end else if (cmd == CMD_FETCH) begin
                  nxt_dirty[i] = 1'b0;
               end else if (is_update) begin
                  nxt_dirty[i] = 1'b1;
               end
            end
         end else if (cur_valid[i]) begin
            if (touch && (cur_rank[i] < old_rank)) begin
               nxt_rank[i] = cur_rank[i] + RANK_BITS'(1);
            end else if (drop && (cur_rank[i] > old_rank)) begin
               nxt_rank[i] = cur_rank[i] - RANK_BITS'(1);
            end
         end
      end
   end

   assign status.missing = !is_update && !found_hit;
   assign status.evicted = fill && !found_free;
   assign victim_tag     = lru_tag;

endmodule

// ===== hdl/set_assoc_lru_tag_store.sv =====
// ----------------------------------------------------------------------------
// Set-associative LRU tag store
// Tag, valid, dirty and recency state of a set-associative cache with true
// LRU replacement, taking read, invalidate, fetch and update commands.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low and
// returns one result item for each, in order. An accepted item has its
// set row read from the row memory into its registered read port and its
// command and address taken into the input register; the way logic then
// compares all ways in parallel, and when the result register is free or
// being taken the updated row is written back and the result is registered.
// A read that hits the row being written in the same cycle is given the
// new row, so items to the same set may follow one another back to back.
// The output register and the input register let the block take a new
// item while a result waits, and outside the clearing pass req_stall is
// raised only when both are full and the waiting result is held off.
// After reset a clearing pass writes every set row once, during which
// req_stall is held high. A miss on read, invalidate or fetch sets
// line_missing and leaves the state as it was; an update that replaces a
// valid line sets evicted and reports the old line's address.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store #(
   parameter int SET_BITS    = lru_ts_pkg::DEF_SET_BITS,
   parameter int WAYS        = lru_ts_pkg::DEF_WAYS,
   parameter int OFFSET_BITS = lru_ts_pkg::DEF_OFFSET_BITS,
   parameter int ADDR_BITS   = lru_ts_pkg::DEF_ADDR_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [lru_ts_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic [lru_ts_pkg::FIELD_ADDR_BITS-1:0]  req_address,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [lru_ts_pkg::CMD_BITS-1:0]         rsp_reply_kind,
   output logic [lru_ts_pkg::FIELD_ADDR_BITS-1:0]  rsp_reply_address,
   output logic                                    rsp_line_missing,
   output logic                                    rsp_evicted,
   output logic [lru_ts_pkg::FIELD_ADDR_BITS-1:0]  rsp_victim_address
);

   import lru_ts_pkg::*;

   // Address bits above the narrower of ADDR_BITS and the port are ignored.
   localparam int EFF_ADDR_BITS = (ADDR_BITS < FIELD_ADDR_BITS) ? ADDR_BITS
                                                                : FIELD_ADDR_BITS;
   localparam int LOW_BITS      = SET_BITS + OFFSET_BITS;
   localparam int TAG_BITS      = EFF_ADDR_BITS - LOW_BITS;
   localparam int NUM_SETS      = 1 << SET_BITS;
   localparam int SET_IDX_BITS  = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int RANK_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_BITS      = WAYS * (2 + RANK_BITS + TAG_BITS);
   localparam logic [SET_IDX_BITS-1:0] LAST_SET = SET_IDX_BITS'(NUM_SETS - 1);

   // Clearing pass after reset.
   logic                    clr_active_ff;
   logic [SET_IDX_BITS-1:0] clr_idx_ff;

   // Input register.
   logic                     s1_valid_ff;
   logic [CMD_BITS-1:0]      s1_cmd_ff;
   logic [EFF_ADDR_BITS-1:0] s1_addr_ff;

   // Result register.
   logic                       rsp_valid_ff;
   logic [CMD_BITS-1:0]        rsp_kind_ff;
   logic [FIELD_ADDR_BITS-1:0] rsp_addr_ff;
   logic                       rsp_missing_ff;
   logic                       rsp_evicted_ff;
   logic [FIELD_ADDR_BITS-1:0] rsp_victim_ff;

   // Handshake and memory control.
   logic                     out_ready;
   logic                     advance;
   logic                     accept;
   logic [EFF_ADDR_BITS-1:0] req_addr_eff;
   logic [SET_IDX_BITS-1:0]  req_set;
   logic [SET_IDX_BITS-1:0]  s1_set;
   logic [TAG_BITS-1:0]      s1_tag;
   logic                     mem_wr_en;
   logic [SET_IDX_BITS-1:0]  mem_wr_addr;
   logic [ROW_BITS-1:0]      mem_wr_data;
   logic [ROW_BITS-1:0]      mem_rd_data;

   // Current and updated set row.
   logic [WAYS-1:0]                cur_valid;
   logic [WAYS-1:0]                cur_dirty;
   logic [WAYS-1:0][RANK_BITS-1:0] cur_rank;
   logic [WAYS-1:0][TAG_BITS-1:0]  cur_tag;
   logic [WAYS-1:0]                nxt_valid;
   logic [WAYS-1:0]                nxt_dirty;
   logic [WAYS-1:0][RANK_BITS-1:0] nxt_rank;
   logic [WAYS-1:0][TAG_BITS-1:0]  nxt_tag;
   lookup_status_type              status;
   logic [TAG_BITS-1:0]            victim_tag;
   logic [FIELD_ADDR_BITS-1:0]     victim_addr;

   // The result register frees up when it is empty or being taken; the item
   // in the input register moves on whenever the result register can take it.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = clr_active_ff || (s1_valid_ff && !out_ready);
   assign accept    = req_valid && !req_stall;

   assign req_addr_eff = req_address[EFF_ADDR_BITS-1:0];
   assign req_set      = (SET_BITS == 0) ? '0
                                         : SET_IDX_BITS'(req_addr_eff >> OFFSET_BITS);
   assign s1_set       = (SET_BITS == 0) ? '0
                                         : SET_IDX_BITS'(s1_addr_ff >> OFFSET_BITS);
   assign s1_tag       = s1_addr_ff[EFF_ADDR_BITS-1:LOW_BITS];

   // During the clearing pass every row is written with all lines invalid.
   assign mem_wr_en   = clr_active_ff || advance;
   assign mem_wr_addr = clr_active_ff ? clr_idx_ff : s1_set;
   assign mem_wr_data = clr_active_ff ? '0 : {nxt_valid, nxt_dirty, nxt_rank, nxt_tag};

   assign {cur_valid, cur_dirty, cur_rank, cur_tag} = mem_rd_data;

   lru_ts_row_mem #(
      .DATA_BITS (ROW_BITS),
      .DEPTH     (NUM_SETS)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (mem_rd_data)
   );

   lru_ts_way_logic #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS)
   ) u_way_logic (
      .cmd        (s1_cmd_ff),
      .tag        (s1_tag),
      .cur_valid  (cur_valid),
      .cur_dirty  (cur_dirty),
      .cur_rank   (cur_rank),
      .cur_tag    (cur_tag),
      .nxt_valid  (nxt_valid),
      .nxt_dirty  (nxt_dirty),
      .nxt_rank   (nxt_rank),
      .nxt_tag    (nxt_tag),
      .status     (status),
      .victim_tag (victim_tag)
   );

   // The evicted line keeps the request's set and offset bits.
   assign victim_addr = status.evicted
                        ? FIELD_ADDR_BITS'({victim_tag, s1_addr_ff[LOW_BITS-1:0]})
                        : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_idx_ff == LAST_SET) begin
            clr_active_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + SET_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_addr_ff <= req_addr_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff    <= s1_cmd_ff;
         rsp_addr_ff    <= FIELD_ADDR_BITS'(s1_addr_ff);
         rsp_missing_ff <= status.missing;
         rsp_evicted_ff <= status.evicted;
         rsp_victim_ff  <= victim_addr;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_kind     = rsp_kind_ff;
   assign rsp_reply_address  = rsp_addr_ff;
   assign rsp_line_missing   = rsp_missing_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_victim_address = rsp_victim_ff;

   // No item may enter while the clearing pass is still writing rows.
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> req_stall)
      else $error("item accepted during the clearing pass");

   // An item that moves on always produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after the lookup");

   // An update never reports a missing line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == CMD_UPDATE)) |-> !rsp_missing_ff)
      else $error("update reported a missing line");

   // Only an update can evict, and only after a lookup that found no hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |->
         ((rsp_kind_ff == CMD_UPDATE) && !rsp_missing_ff))
      else $error("eviction reported for a command other than update");

   // The victim address is zero unless a line was evicted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_evicted_ff) |-> (rsp_victim_ff == '0))
      else $error("victim address set without an eviction");

endmodule

// ===== tb/set_assoc_lru_tag_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU tag store testbench
// Drives read, invalidate, fetch and update items into the tag store, keeps
// its own model of the valid, dirty, tag and age state of every line, and
// compares each result item field by field with the predicted reply.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store_test;
   import lru_ts_pkg::*;

   // Geometry of the instance under test; the block is built with its
   // defaults, so the model follows the same defaults from the package.
   localparam int SET_BITS    = DEF_SET_BITS;
   localparam int WAYS        = DEF_WAYS;
   localparam int OFFSET_BITS = DEF_OFFSET_BITS;
   localparam int ADDR_W      = FIELD_ADDR_BITS;
   localparam int NUM_SETS    = 1 << SET_BITS;
   localparam int NUM_LINES   = NUM_SETS * WAYS;
   localparam int LOW_BITS    = SET_BITS + OFFSET_BITS;
   localparam int TAG_W       = ADDR_W - LOW_BITS;
   localparam int AGE_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Distinct tags kept per set for random traffic. It is larger than the
   // number of ways, so a set keeps hitting but also has to replace lines.
   localparam int POOL_TAGS    = 6;
   localparam int MAX_REPORTS  = 10;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      cmd_type             kind;
      logic [ADDR_W-1:0]   address;
      logic                missing;
      logic                evicted;
      logic [ADDR_W-1:0]   victim;
   } tag_reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_BITS-1:0]   req_cmd;
   logic [ADDR_W-1:0]     req_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CMD_BITS-1:0]   rsp_reply_kind;
   logic [ADDR_W-1:0]     rsp_reply_address;
   logic                  rsp_line_missing;
   logic                  rsp_evicted;
   logic [ADDR_W-1:0]     rsp_victim_address;

   // Model of the tag store: one entry per line, indexed set * WAYS + way.
   // Age 0 is the most recently used line of a set.
   logic                  line_live [NUM_LINES];
   logic                  line_dirt [NUM_LINES];
   logic [TAG_W-1:0]      line_tag  [NUM_LINES];
   logic [AGE_W-1:0]      line_age  [NUM_LINES];

   tag_reply_type         expected_replies[$];
   logic [TAG_W-1:0]      tag_pool [NUM_SETS][POOL_TAGS];

   // Idle behaviour of both sides, changed from one test to the next.
   int                    send_gap_max = 0;
   int                    recv_gap_max = 0;
   int                    recv_hold_len = 0;

   int                    mismatches = 0;
   int                    items_by_cmd [4];
   int                    misses_seen = 0;
   int                    evictions_seen = 0;
   int                    quiet_cycles = 0;

   set_assoc_lru_tag_store dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_reply_address  (rsp_reply_address),
      .rsp_line_missing   (rsp_line_missing),
      .rsp_evicted        (rsp_evicted),
      .rsp_victim_address (rsp_victim_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Tag store model
   // ------------------------------------------------------------------------

   // Touching a line makes it the youngest; every valid line of the set that
   // was younger than it grows one step older.
   function automatic void touch_line(input int base, input int way);
      logic [AGE_W-1:0] was;
      was = line_age[base + way];
      for (int i = 0; i < WAYS; i++) begin
         if (i != way && line_live[base + i] && line_age[base + i] < was)
            line_age[base + i] = line_age[base + i] + AGE_W'(1);
      end
      line_age[base + way] = '0;
   endfunction

   // Dropping a line lets every older valid line of the set move one step
   // younger, so the ages of the valid lines stay dense from zero.
   function automatic void drop_line(input int base, input int way);
      logic [AGE_W-1:0] was;
      was = line_age[base + way];
      for (int i = 0; i < WAYS; i++) begin
         if (i != way && line_live[base + i] && line_age[base + i] > was)
            line_age[base + i] = line_age[base + i] - AGE_W'(1);
      end
      line_live[base + way] = 1'b0;
      line_age[base + way]  = '0;
   endfunction

   // Works out the reply to one command and applies its effect on the state.
   function automatic tag_reply_type predict_lookup(input cmd_type cmd,
                                                    input logic [ADDR_W-1:0] addr);
      tag_reply_type    reply;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] oldest;
      int               base;
      int               hit;
      int               free_way;
      int               way;
      tag      = addr[ADDR_W-1:LOW_BITS];
      base     = int'(addr[OFFSET_BITS +: SET_BITS]) * WAYS;
      hit      = -1;
      free_way = -1;
      // All ways are searched; the lowest matching valid way wins, and the
      // lowest invalid way is the one a fill would take.
      for (int i = 0; i < WAYS; i++) begin
         if (line_live[base + i]) begin
            if (hit < 0 && line_tag[base + i] == tag)
               hit = i;
         end else if (free_way < 0) begin
            free_way = i;
         end
      end
      reply.kind    = cmd;
      reply.address = addr;
      reply.missing = 1'b0;
      reply.evicted = 1'b0;
      reply.victim  = '0;
      if (cmd == CMD_UPDATE) begin
         if (hit >= 0) begin
            line_dirt[base + hit] = 1'b1;
            touch_line(base, hit);
         end else begin
            if (free_way >= 0) begin
               way = free_way;
            end else begin
               // A full set gives up its oldest line, the lowest way on a tie.
               oldest = '0;
               way    = 0;
               for (int i = 0; i < WAYS; i++) begin
                  if (line_age[base + i] > oldest) begin
                     oldest = line_age[base + i];
                     way    = i;
                  end
               end
               reply.evicted = 1'b1;
               reply.victim  = {line_tag[base + way], addr[LOW_BITS-1:0]};
            end
            // The new line enters as the oldest and is then touched, so every
            // other valid line of the set ages by one.
            line_live[base + way] = 1'b1;
            line_dirt[base + way] = 1'b1;
            line_tag[base + way]  = tag;
            line_age[base + way]  = AGE_W'(WAYS - 1);
            touch_line(base, way);
         end
      end else if (hit < 0) begin
         // A miss on read, invalidate or fetch is flagged and changes nothing.
         reply.missing = 1'b1;
      end else begin
         case (cmd)
            CMD_READ: begin
               touch_line(base, hit);
            end
            CMD_INVALIDATE: begin
               drop_line(base, hit);
            end
            CMD_FETCH: begin
               line_dirt[base + hit] = 1'b0;
               touch_line(base, hit);
            end
            default: begin
            end
         endcase
      end
      return reply;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [ADDR_W-1:0] line_address(input logic [TAG_W-1:0] tag,
                                                      input int set,
                                                      input int offset);
      return {tag, SET_BITS'(set), OFFSET_BITS'(offset)};
   endfunction

   function automatic logic [ADDR_W-1:0] random_word();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[ADDR_W-1:0];
   endfunction

   // Updates dominate so that sets fill and replace; the rest are split so
   // that reads, fetches and invalidates hit often enough to reorder ages.
   function automatic cmd_type pick_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return CMD_UPDATE;
      else if (roll < 65)
         return CMD_READ;
      else if (roll < 80)
         return CMD_FETCH;
      return CMD_INVALIDATE;
   endfunction

   // Mostly an address from the tag pool of a random set, now and then a
   // wholly random address that will almost always miss.
   function automatic logic [ADDR_W-1:0] traffic_address();
      int set;
      if ($urandom_range(0, 19) == 0)
         return random_word();
      set = $urandom_range(0, NUM_SETS - 1);
      return line_address(tag_pool[set][$urandom_range(0, POOL_TAGS - 1)], set,
                          $urandom_range(0, (1 << OFFSET_BITS) - 1));
   endfunction

   // Fresh tags for every set. The first two slots are sometimes the extreme
   // tags, so that all-zero and all-one tags also live in the cache.
   function automatic void refill_tag_pool();
      logic [ADDR_W-1:0] word;
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int k = 0; k < POOL_TAGS; k++) begin
            word = random_word();
            tag_pool[s][k] = word[TAG_W-1:0];
         end
         if ($urandom_range(0, 3) == 0)
            tag_pool[s][0] = '0;
         if ($urandom_range(0, 3) == 0)
            tag_pool[s][1] = '1;
      end
   endfunction

   // Offers one item after a random gap and returns once it is accepted. The
   // expected reply is worked out when the item is offered; items are
   // accepted in the order they are offered, so the order holds.
   task automatic send_item(input cmd_type cmd, input logic [ADDR_W-1:0] addr);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_cmd     = cmd;
      req_address = addr;
      req_valid   = 1'b1;
      expected_replies.push_back(predict_lookup(cmd, addr));
      items_by_cmd[int'(cmd)]++;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
   endtask

   task automatic send_random_item();
      send_item(pick_cmd(), traffic_address());
   endtask

   // Withdraws the request and waits until every reply has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every lookup on an empty cache misses, whatever the address.
   task automatic test_empty_lookups();
      send_gap_max = 0;
      recv_gap_max = 0;
      send_item(CMD_READ, '0);
      send_item(CMD_INVALIDATE, '1);
      send_item(CMD_FETCH, random_word());
      wait_drained();
   endtask

   // Fills one set, replaces its oldest line, and walks through hits of every
   // kind, an invalidate of the oldest line of the set and a refill of the
   // freed way. Items follow one another back to back, so each depends on
   // the state that the one before it has just written.
   task automatic test_fill_and_replace();
      logic [TAG_W-1:0] tag_a;
      logic [TAG_W-1:0] tag_b;
      logic [TAG_W-1:0] tag_c;
      logic [TAG_W-1:0] tag_d;
      logic [TAG_W-1:0] tag_e;
      logic [ADDR_W-1:0] word;
      int               top_set;
      int               top_off;
      send_gap_max = 0;
      recv_gap_max = 0;
      top_set = NUM_SETS - 1;
      top_off = (1 << OFFSET_BITS) - 1;
      tag_a   = '0;
      tag_b   = '1;
      tag_c   = {(TAG_W + 7) / 8{8'h5a}};
      tag_d   = {(TAG_W + 7) / 8{8'ha5}};
      word    = random_word();
      tag_e   = word[TAG_W-1:0];
      send_item(CMD_UPDATE, line_address(tag_a, top_set, 0));
      send_item(CMD_UPDATE, line_address(tag_b, top_set, top_off));
      send_item(CMD_UPDATE, line_address(tag_c, top_set, 21));
      send_item(CMD_UPDATE, line_address(tag_d, top_set, 42));
      send_item(CMD_READ, line_address(tag_a, top_set, 7));
      // The set is full: the oldest line goes, with an all-ones victim.
      send_item(CMD_UPDATE, line_address(tag_e, top_set, top_off));
      send_item(CMD_UPDATE, line_address(tag_c, top_set, 0));
      send_item(CMD_FETCH, line_address(tag_d, top_set, 3));
      send_item(CMD_INVALIDATE, line_address(tag_a, top_set, 0));
      send_item(CMD_INVALIDATE, line_address(tag_a, top_set, 0));
      send_item(CMD_UPDATE, line_address(tag_b, top_set, 9));
      send_item(CMD_UPDATE, line_address(tag_a, top_set, 0));
      send_item(CMD_READ, line_address(tag_e, top_set, top_off));
      send_item(CMD_FETCH, line_address(tag_c, top_set, 1));
      // Same tag in another set is a different line and misses.
      send_item(CMD_READ, line_address(tag_b, 0, top_off));
      send_item(CMD_UPDATE, line_address(tag_b, 0, top_off));
      send_item(CMD_INVALIDATE, line_address(tag_b, 0, 0));
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering items, so the block fills up and has to stall its input.
   task automatic test_back_pressure();
      send_gap_max  = 0;
      recv_gap_max  = 0;
      recv_hold_len = HOLD_CYCLES;
      refill_tag_pool();
      repeat (40)
         send_random_item();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int send_max,
                                      input int recv_max);
      send_gap_max = send_max;
      recv_gap_max = recv_max;
      refill_tag_pool();
      repeat (count)
         send_random_item();
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // The receiver draws a stall length for each result item; a long hold
   // asked for by a test replaces one draw.
   initial begin : reply_receiver
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if (recv_hold_len > 0) begin
            hold = recv_hold_len;
            recv_hold_len = 0;
         end else begin
            hold = $urandom_range(0, recv_gap_max);
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do
            @(posedge clock);
         while (rsp_valid !== 1'b1);
      end
   end

   // Each accepted result item is compared with the oldest outstanding reply.
   always @(posedge clock) begin : reply_checker
      tag_reply_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result item with no outstanding request: kind %0d addr %h",
                        $realtime, rsp_reply_kind, rsp_reply_address);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_reply_kind !== want.kind || rsp_reply_address !== want.address ||
                rsp_line_missing !== want.missing || rsp_evicted !== want.evicted ||
                rsp_victim_address !== want.victim) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: expected kind %0d addr %h missing %b evicted %b victim %h",
                           $realtime, want.kind, want.address, want.missing,
                           want.evicted, want.victim);
                  $display("%0t: actual   kind %0d addr %h missing %b evicted %b victim %h",
                           $realtime, rsp_reply_kind, rsp_reply_address,
                           rsp_line_missing, rsp_evicted, rsp_victim_address);
               end
            end
            if (rsp_line_missing === 1'b1)
               misses_seen++;
            if (rsp_evicted === 1'b1)
               evictions_seen++;
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d replies outstanding",
                     QUIET_LIMIT, expected_replies.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_READ;
      req_address = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         line_live[i] = 1'b0;
         line_dirt[i] = 1'b0;
         line_tag[i]  = '0;
         line_age[i]  = '0;
      end
      for (int i = 0; i < 4; i++)
         items_by_cmd[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_lookups();
      test_fill_and_replace();
      test_back_pressure();
      test_random_traffic(400, 0, 0);
      test_random_traffic(400, 12, 12);
      test_random_traffic(350, 0, 12);
      test_random_traffic(350, 12, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d reads, %0d invalidates, %0d fetches and %0d updates",
               items_by_cmd[int'(CMD_READ)], items_by_cmd[int'(CMD_INVALIDATE)],
               items_by_cmd[int'(CMD_FETCH)], items_by_cmd[int'(CMD_UPDATE)]);
      $display("with %0d lookup misses, %0d evictions, random idling and a long hold",
               misses_seen, evictions_seen);
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d replies outstanding", mismatches,
                  expected_replies.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lru_ts_pkg.sv
hdl/lru_ts_row_mem.sv
hdl/lru_ts_way_logic.sv
hdl/set_assoc_lru_tag_store.sv
tb/set_assoc_lru_tag_store_test.sv
